// ===== src/twcm_pkg.sv =====
// shared types and constants of the textured wall column mapper
`default_nettype none
package twcm_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int COORD_W    = 12;
    localparam int SCR_DIM_W  = 13;
    localparam int TEX_DIM_W  = 11;
    localparam int TEXEL_W    = 10;
    localparam int LINE_W     = 16;
    localparam int WFRAC_W    = 16;
    localparam int TEX_SEL_W  = 2;
    localparam int COLOR_W    = 24;
    localparam int POS_W      = 32;
    localparam int BASE_W     = 18;
    localparam int DIVIDEND_W = TEX_DIM_W + FRAC_BITS;
    localparam int DIV_CNT_W  = 5;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam int KIND_W     = 2;
    localparam int SIGN_W     = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SCREEN_WIDTH   = 3'd0,
        REG_SCREEN_HEIGHT  = 3'd1,
        REG_TEXTURE_WIDTH  = 3'd2,
        REG_TEXTURE_HEIGHT = 3'd3,
        REG_CEILING_COLOR  = 3'd4,
        REG_FLOOR_COLOR    = 3'd5
    } twcm_reg_e;

    typedef enum logic [KIND_W-1:0] {
        KIND_CEILING = 2'd0,
        KIND_WALL    = 2'd1,
        KIND_FLOOR   = 2'd2
    } twcm_kind_e;

    typedef enum logic [SIGN_W-1:0] {
        RAY_ZERO     = 2'd0,
        RAY_POSITIVE = 2'd1,
        RAY_NEGATIVE = 2'd2
    } twcm_sign_e;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIV,
        ST_MUL,
        ST_EMIT
    } twcm_state_e;

    typedef struct packed {
        logic [COORD_W-1:0]   column;
        logic [COORD_W-1:0]   row;
        logic [COORD_W-1:0]   wall_top;
        logic [LINE_W-1:0]    line_height;
        logic [WFRAC_W-1:0]   wall_fraction;
        logic [TEX_SEL_W-1:0] texture_select;
        logic                 hit_side;
        logic [SIGN_W-1:0]    ray_x_sign;
    } twcm_pix_in_t;

    typedef struct packed {
        logic [KIND_W-1:0]    pixel_kind;
        logic [COLOR_W-1:0]   fill_color;
        logic [TEX_SEL_W-1:0] texture_index;
        logic [TEXEL_W-1:0]   texel_col;
        logic [TEXEL_W-1:0]   texel_row;
        logic                 write_enable;
        logic [COORD_W-1:0]   frame_row;
        logic [COORD_W-1:0]   frame_col;
    } twcm_pix_out_t;

    typedef struct packed {
        logic capture;
        logic div_start;
        logic div_step;
        logic latch;
        logic emit;
    } twcm_cmd_t;

    typedef struct packed {
        logic latch_needed;
        logic div_last;
        logic out_free;
    } twcm_status_t;

endpackage
`default_nettype wire

// ===== src/twcm_ifs.sv =====
// valid/ready channel interfaces for pixels in, pixels out and register writes
`default_nettype none
interface twcm_pix_in_if;
    logic                                  valid;
    logic                                  ready;
    logic [twcm_pkg::COORD_W-1:0]          column;
    logic [twcm_pkg::COORD_W-1:0]          row;
    logic [twcm_pkg::COORD_W-1:0]          wall_top;
    logic [twcm_pkg::LINE_W-1:0]           line_height;
    logic [twcm_pkg::WFRAC_W-1:0]          wall_fraction;
    logic [twcm_pkg::TEX_SEL_W-1:0]        texture_select;
    logic                                  hit_side;
    logic [twcm_pkg::SIGN_W-1:0]           ray_x_sign;

    modport source (
        output valid, column, row, wall_top, line_height, wall_fraction,
               texture_select, hit_side, ray_x_sign,
        input  ready
    );
    modport sink (
        input  valid, column, row, wall_top, line_height, wall_fraction,
               texture_select, hit_side, ray_x_sign,
        output ready
    );
endinterface

interface twcm_pix_out_if;
    logic                                  valid;
    logic                                  ready;
    logic [twcm_pkg::KIND_W-1:0]           pixel_kind;
    logic [twcm_pkg::COLOR_W-1:0]          fill_color;
    logic [twcm_pkg::TEX_SEL_W-1:0]        texture_index;
    logic [twcm_pkg::TEXEL_W-1:0]          texel_col;
    logic [twcm_pkg::TEXEL_W-1:0]          texel_row;
    logic                                  write_enable;
    logic [twcm_pkg::COORD_W-1:0]          frame_row;
    logic [twcm_pkg::COORD_W-1:0]          frame_col;

    modport source (
        output valid, pixel_kind, fill_color, texture_index, texel_col, texel_row,
               write_enable, frame_row, frame_col,
        input  ready
    );
    modport sink (
        input  valid, pixel_kind, fill_color, texture_index, texel_col, texel_row,
               write_enable, frame_row, frame_col,
        output ready
    );
endinterface

interface twcm_cfg_if;
    logic                                  valid;
    logic                                  ready;
    logic [twcm_pkg::CFG_IDX_W-1:0]        index;
    logic [twcm_pkg::CFG_DATA_W-1:0]       data;

    modport source (
        output valid, index, data,
        input  ready
    );
    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface
`default_nettype wire

// ===== src/textured_wall_column_mapper_core.sv =====
// ceiling, floor and later wall rows: capture, check, then the output register load, which waits
// while the output stalls; the first wall row of a column adds a restoring divider for the step
// and the start position product before that load; a new pixel is taken only when idle, after
// the last one is loaded into the output register
// reset: asynchronous active low, config registers return to their defaults, column state to zero
`default_nettype none
module textured_wall_column_mapper_core (
    input  wire logic     clk,
    input  wire logic     rst_n,
    twcm_pix_in_if.sink   pix_in,
    twcm_pix_out_if.source pix_out,
    twcm_cfg_if.sink      cfg
);

    twcm_pkg::twcm_cmd_t     cmd;
    twcm_pkg::twcm_status_t  status;
    twcm_pkg::twcm_pix_in_t  in_item;
    twcm_pkg::twcm_pix_out_t out_item;
    logic                    in_ready;
    logic                    out_valid;
    logic                    cfg_we;

    // register writes are always taken, so the port never stalls
    assign cfg.ready = 1'b1;
    assign cfg_we    = cfg.valid && cfg.ready;

    // pack the incoming transaction payload
    assign in_item.column         = pix_in.column;
    assign in_item.row            = pix_in.row;
    assign in_item.wall_top       = pix_in.wall_top;
    assign in_item.line_height    = pix_in.line_height;
    assign in_item.wall_fraction  = pix_in.wall_fraction;
    assign in_item.texture_select = pix_in.texture_select;
    assign in_item.hit_side       = pix_in.hit_side;
    assign in_item.ray_x_sign     = pix_in.ray_x_sign;
    assign pix_in.ready           = in_ready;

    // sequencer: capture, optional step divide and start latch, then emit
    twcm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (pix_in.valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    // datapath holds config, column state, divider and the output register
    twcm_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .in_item   (in_item),
        .cfg_we    (cfg_we),
        .cfg_index (cfg.index),
        .cfg_data  (cfg.data),
        .out_valid (out_valid),
        .out_ready (pix_out.ready),
        .out_item  (out_item)
    );

    // unpack the outgoing transaction
    assign pix_out.valid         = out_valid;
    assign pix_out.pixel_kind    = out_item.pixel_kind;
    assign pix_out.fill_color    = out_item.fill_color;
    assign pix_out.texture_index = out_item.texture_index;
    assign pix_out.texel_col     = out_item.texel_col;
    assign pix_out.texel_row     = out_item.texel_row;
    assign pix_out.write_enable  = out_item.write_enable;
    assign pix_out.frame_row     = out_item.frame_row;
    assign pix_out.frame_col     = out_item.frame_col;

endmodule
`default_nettype wire

// ===== src/twcm_ctrl.sv =====
// controller state machine sequencing capture, step division, start product and emit
`default_nettype none
module twcm_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire twcm_pkg::twcm_status_t status,
    output twcm_pkg::twcm_cmd_t       cmd
);

    twcm_pkg::twcm_state_e state_reg;
    twcm_pkg::twcm_state_e state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= twcm_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            twcm_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = twcm_pkg::ST_CHECK;
                end
            end
            twcm_pkg::ST_CHECK:
            begin
                if (status.latch_needed)
                begin
                    state_next = twcm_pkg::ST_DIV;
                end
                else if (status.out_free)
                begin
                    state_next = twcm_pkg::ST_IDLE;
                end
                else
                begin
                    state_next = twcm_pkg::ST_EMIT;
                end
            end
            twcm_pkg::ST_DIV:
            begin
                if (status.div_last)
                begin
                    state_next = twcm_pkg::ST_MUL;
                end
            end
            twcm_pkg::ST_MUL:
            begin
                state_next = twcm_pkg::ST_EMIT;
            end
            twcm_pkg::ST_EMIT:
            begin
                if (status.out_free)
                begin
                    state_next = twcm_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = twcm_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        in_ready = 1'b0;
        cmd      = '0;
        case (state_reg)
            twcm_pkg::ST_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
            end
            twcm_pkg::ST_CHECK:
            begin
                if (status.latch_needed)
                begin
                    cmd.div_start = 1'b1;
                end
                else
                begin
                    cmd.emit = status.out_free;
                end
            end
            twcm_pkg::ST_DIV:
            begin
                cmd.div_step = 1'b1;
            end
            twcm_pkg::ST_MUL:
            begin
                cmd.latch = 1'b1;
            end
            twcm_pkg::ST_EMIT:
            begin
                cmd.emit = status.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule
`default_nettype wire

// ===== src/twcm_datapath.sv =====
// config registers, pixel classing, step divider, column latch and output register
`default_nettype none
module twcm_datapath (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire twcm_pkg::twcm_cmd_t                cmd,
    output twcm_pkg::twcm_status_t                  status,
    input  wire twcm_pkg::twcm_pix_in_t             in_item,
    input  wire logic                               cfg_we,
    input  wire logic [twcm_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [twcm_pkg::CFG_DATA_W-1:0]    cfg_data,
    output logic                                    out_valid,
    input  wire logic                               out_ready,
    output twcm_pkg::twcm_pix_out_t                 out_item
);

    localparam int DIV_STEPS = twcm_pkg::DIVIDEND_W;

    // configuration
    logic [twcm_pkg::SCR_DIM_W-1:0] screen_width_reg;
    logic [twcm_pkg::SCR_DIM_W-1:0] screen_height_reg;
    logic [twcm_pkg::TEX_DIM_W-1:0] texture_width_reg;
    logic [twcm_pkg::TEX_DIM_W-1:0] texture_height_reg;
    logic [twcm_pkg::COLOR_W-1:0]   ceiling_color_reg;
    logic [twcm_pkg::COLOR_W-1:0]   floor_color_reg;

    // captured pixel
    twcm_pkg::twcm_pix_in_t item_reg;

    // column state
    logic [twcm_pkg::DIVIDEND_W-1:0] step_size_reg;
    logic [twcm_pkg::POS_W-1:0]      texture_position_reg;
    logic [twcm_pkg::TEXEL_W-1:0]    column_texel_reg;

    // divider
    logic [twcm_pkg::LINE_W-1:0]     div_den_reg;
    logic [twcm_pkg::LINE_W-1:0]     div_rem_reg;
    logic [twcm_pkg::DIVIDEND_W-1:0] div_quot_reg;
    logic [twcm_pkg::DIV_CNT_W-1:0]  div_cnt_reg;
    logic [twcm_pkg::LINE_W:0]       div_trial;
    logic                            div_fits;

    // output register
    logic                            out_valid_reg;
    twcm_pkg::twcm_pix_out_t         out_item_reg;

    // classing
    logic signed [twcm_pkg::SCR_DIM_W+1:0] wall_bottom;
    logic signed [twcm_pkg::SCR_DIM_W+1:0] row_s;
    logic is_floor;
    logic is_ceiling;
    logic is_wall;

    // start position and texture column
    logic [twcm_pkg::BASE_W-1:0]                       base;
    logic signed [twcm_pkg::BASE_W+twcm_pkg::DIVIDEND_W:0] start_prod;
    logic [twcm_pkg::WFRAC_W+twcm_pkg::TEX_DIM_W-1:0]  col_prod;
    logic [twcm_pkg::TEX_DIM_W-1:0]                    col_tx;
    logic [twcm_pkg::TEX_DIM_W-1:0]                    col_mirror;
    logic                                              do_mirror;

    // emit
    logic [twcm_pkg::TEX_DIM_W-1:0] th_m1;
    logic [twcm_pkg::TEXEL_W-1:0]   row_mask;
    twcm_pkg::twcm_pix_out_t        result;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            screen_width_reg   <= twcm_pkg::SCR_DIM_W'(640);
            screen_height_reg  <= twcm_pkg::SCR_DIM_W'(480);
            texture_width_reg  <= twcm_pkg::TEX_DIM_W'(64);
            texture_height_reg <= twcm_pkg::TEX_DIM_W'(64);
            ceiling_color_reg  <= '0;
            floor_color_reg    <= '0;
        end
        else if (cfg_we)
        begin
            case (twcm_pkg::twcm_reg_e'(cfg_index))
                twcm_pkg::REG_SCREEN_WIDTH:
                    screen_width_reg <= cfg_data[twcm_pkg::SCR_DIM_W-1:0];
                twcm_pkg::REG_SCREEN_HEIGHT:
                    screen_height_reg <= cfg_data[twcm_pkg::SCR_DIM_W-1:0];
                twcm_pkg::REG_TEXTURE_WIDTH:
                    texture_width_reg <= cfg_data[twcm_pkg::TEX_DIM_W-1:0];
                twcm_pkg::REG_TEXTURE_HEIGHT:
                    texture_height_reg <= cfg_data[twcm_pkg::TEX_DIM_W-1:0];
                twcm_pkg::REG_CEILING_COLOR:
                    ceiling_color_reg <= cfg_data[twcm_pkg::COLOR_W-1:0];
                twcm_pkg::REG_FLOOR_COLOR:
                    floor_color_reg <= cfg_data[twcm_pkg::COLOR_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            item_reg <= in_item;
        end
    end

    // wall spans wall_top .. screen_height - wall_top
    assign wall_bottom = $signed({2'b00, screen_height_reg})
                       - $signed({3'b000, item_reg.wall_top});
    assign row_s       = $signed({3'b000, item_reg.row});
    assign is_floor    = row_s > wall_bottom;
    assign is_ceiling  = !is_floor && (item_reg.row < item_reg.wall_top);
    assign is_wall     = !is_floor && !is_ceiling;

    // restoring divider, one quotient bit per cycle
    assign div_trial = {div_rem_reg, div_quot_reg[twcm_pkg::DIVIDEND_W-1]};
    assign div_fits  = div_trial >= {1'b0, div_den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_cnt_reg <= '0;
        end
        else if (cmd.div_start)
        begin
            div_cnt_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            div_cnt_reg <= div_cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.div_start)
        begin
            div_den_reg  <= (item_reg.line_height == '0) ? twcm_pkg::LINE_W'(1)
                                                         : item_reg.line_height;
            div_rem_reg  <= '0;
            div_quot_reg <= {texture_height_reg, twcm_pkg::FRAC_BITS'(0)};
        end
        else if (cmd.div_step)
        begin
            if (div_fits)
            begin
                div_rem_reg <= twcm_pkg::LINE_W'(div_trial - {1'b0, div_den_reg});
            end
            else
            begin
                div_rem_reg <= div_trial[twcm_pkg::LINE_W-1:0];
            end
            div_quot_reg <= {div_quot_reg[twcm_pkg::DIVIDEND_W-2:0], div_fits};
        end
    end

    assign status.div_last     = div_cnt_reg == twcm_pkg::DIV_CNT_W'(DIV_STEPS - 1);
    assign status.latch_needed = is_wall && (item_reg.row == item_reg.wall_top);
    assign status.out_free     = !out_valid_reg || out_ready;

    // base = wall_top - screen_height/2 + line_height/2, two's complement
    assign base = {6'b0, item_reg.wall_top}
                - {6'b0, screen_height_reg[twcm_pkg::SCR_DIM_W-1:1]}
                + {3'b0, item_reg.line_height[twcm_pkg::LINE_W-1:1]};
    assign start_prod = $signed(base) * $signed({1'b0, div_quot_reg});

    assign col_prod   = item_reg.wall_fraction * texture_width_reg;
    assign col_tx     = col_prod[twcm_pkg::WFRAC_W +: twcm_pkg::TEX_DIM_W];
    assign col_mirror = texture_width_reg - col_tx - twcm_pkg::TEX_DIM_W'(1);
    assign do_mirror  = (!item_reg.hit_side
                         && item_reg.ray_x_sign == twcm_pkg::RAY_POSITIVE)
                     || (item_reg.hit_side
                         && item_reg.ray_x_sign == twcm_pkg::RAY_NEGATIVE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_size_reg        <= '0;
            texture_position_reg <= '0;
            column_texel_reg     <= '0;
        end
        else if (cmd.latch)
        begin
            step_size_reg        <= div_quot_reg;
            texture_position_reg <= start_prod[twcm_pkg::POS_W-1:0];
            column_texel_reg     <= do_mirror ? col_mirror[twcm_pkg::TEXEL_W-1:0]
                                              : col_tx[twcm_pkg::TEXEL_W-1:0];
        end
        else if (cmd.emit && is_wall)
        begin
            texture_position_reg <= texture_position_reg
                                  + {{(twcm_pkg::POS_W-twcm_pkg::DIVIDEND_W){1'b0}},
                                     step_size_reg};
        end
    end

    assign th_m1    = texture_height_reg - twcm_pkg::TEX_DIM_W'(1);
    assign row_mask = (texture_height_reg == '0) ? '0 : th_m1[twcm_pkg::TEXEL_W-1:0];

    always_comb
    begin
        result               = '0;
        result.write_enable  = ({1'b0, item_reg.row} < screen_height_reg)
                            && ({1'b0, item_reg.column} < screen_width_reg);
        result.frame_row     = item_reg.row;
        result.frame_col     = item_reg.column;
        if (is_floor)
        begin
            result.pixel_kind = twcm_pkg::KIND_FLOOR;
            result.fill_color = floor_color_reg;
        end
        else if (is_ceiling)
        begin
            result.pixel_kind = twcm_pkg::KIND_CEILING;
            result.fill_color = ceiling_color_reg;
        end
        else
        begin
            result.pixel_kind    = twcm_pkg::KIND_WALL;
            result.texture_index = item_reg.texture_select;
            result.texel_col     = column_texel_reg;
            result.texel_row     = texture_position_reg[twcm_pkg::FRAC_BITS +: twcm_pkg::TEXEL_W]
                                 & row_mask;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_item_reg <= result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule
`default_nettype wire
